// ===== design/xtq_pkg.sv =====
`timescale 1ns / 1ps
package xtq_pkg;
   localparam int KeyBits   = 30;
   localparam int NodeCount = 4096;
   localparam int CountBits = 16;
   localparam int NodeBits  = $clog2(NodeCount);
   localparam int LevelBits = $clog2(KeyBits);
   localparam int LinkBits  = 2 * NodeBits;

   typedef logic [NodeBits-1:0]  node_type;
   typedef logic [KeyBits-1:0]   key_type;
   typedef logic [CountBits-1:0] count_type;
   typedef logic [LevelBits-1:0] level_type;

   localparam logic [1:0] KIND_CLEAR  = 2'd0;
   localparam logic [1:0] KIND_INSERT = 2'd1;
   localparam logic [1:0] KIND_REMOVE = 2'd2;
   localparam logic [1:0] KIND_QUERY  = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EMPTY     = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic load;        // capture item, start at root
      logic step;        // consume read data, advance level
      logic restart;     // back to root for second pass
      logic clr;         // reset root state
      logic [1:0] mode;  // kind of walk
      logic pass2;
   } cmd_type;

   typedef struct packed {
      logic last_level;
      logic missing;     // needed link absent (or zero count in remove)
      logic root_empty;
      logic root_full;
      logic no_room;
   } sts_type;
endpackage

// ===== design/xtq_ram.sv =====
`timescale 1ns / 1ps
module xtq_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== design/xtq_datapath.sv =====
`timescale 1ns / 1ps
module xtq_datapath (
   input  logic                clock,
   input  logic                reset,
   input  xtq_pkg::cmd_type    cmd,
   output xtq_pkg::sts_type    sts,
   input  logic [29:0]         req_key,
   output logic [29:0]         best_value,
   output logic [29:0]         min_xor,
   output logic [15:0]         stored_count
);
   import xtq_pkg::*;

   key_type   key_ff;
   node_type  node_ff, node_in;
   level_type level_ff;
   key_type   best_ff;
   logic [NodeBits:0] free_ff;
   count_type root_cnt_ff;
   logic [LinkBits-1:0] root_link_ff;
   node_type  rem_ff;   // links still to allocate
   logic fresh_ff;

   logic [LinkBits-1:0] lk_rd, lk_wd, lk_cur;
   count_type cn_rd, cn_wd;
   logic lk_we, cn_we;
   node_type lk_wa, cn_wa, lk_ra, cn_ra;
   logic kb;
   node_type same_ch, other_ch, nxt;
   logic bump;
   logic qsel;

   // a fresh node has no children yet, its stale link entry is not used
   assign kb       = key_ff[level_ff];
   assign lk_cur   = fresh_ff ? '0 : (node_ff == '0) ? root_link_ff : lk_rd;
   assign same_ch  = kb ? lk_cur[LinkBits-1:NodeBits] : lk_cur[NodeBits-1:0];
   assign other_ch = kb ? lk_cur[NodeBits-1:0] : lk_cur[LinkBits-1:NodeBits];

   // child counts are read in the cycle after links
   assign lk_ra = node_ff;
   assign cn_ra = same_ch;

   xtq_ram #(.Width(LinkBits), .Depth(NodeCount)) u_links (
      .clock(clock), .wr_en(lk_we), .wr_addr(lk_wa), .wr_data(lk_wd),
      .rd_addr(lk_ra), .rd_data(lk_rd));
   xtq_ram #(.Width(CountBits), .Depth(NodeCount)) u_counts (
      .clock(clock), .wr_en(cn_we), .wr_addr(cn_wa), .wr_data(cn_wd),
      .rd_addr(cn_ra), .rd_data(cn_rd));

   always_comb begin
      qsel = 1'b1;
      if (same_ch == '0 || cn_rd == '0) qsel = 1'b0;
      nxt = qsel ? same_ch : other_ch;
      bump = (cmd.mode == KIND_INSERT) && cmd.pass2 && (same_ch == '0);
   end

   always_comb begin
      lk_we = 1'b0; lk_wa = node_ff; lk_wd = lk_cur;
      cn_we = 1'b0; cn_wa = same_ch; cn_wd = cn_rd;
      node_in = same_ch;
      if (cmd.step && cmd.pass2 && cmd.mode == KIND_INSERT) begin
         if (same_ch == '0) begin
            node_in = free_ff[NodeBits-1:0];
            lk_we = (node_ff != '0);
            lk_wd = kb ? {free_ff[NodeBits-1:0], lk_cur[NodeBits-1:0]}
                       : {lk_cur[LinkBits-1:NodeBits], free_ff[NodeBits-1:0]};
            cn_we = 1'b1; cn_wa = free_ff[NodeBits-1:0]; cn_wd = count_type'(1);
         end else begin
            cn_we = 1'b1; cn_wd = cn_rd + count_type'(1);
         end
      end else if (cmd.step && cmd.pass2 && cmd.mode == KIND_REMOVE) begin
         cn_we = 1'b1; cn_wd = cn_rd - count_type'(1);
      end
      if (cmd.step && cmd.mode == KIND_QUERY) node_in = nxt;
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clr) begin
         root_cnt_ff  <= '0;
         root_link_ff <= '0;
         free_ff      <= (NodeBits+1)'(1);
      end else if (cmd.step) begin
         if (cmd.mode == KIND_INSERT && cmd.pass2 && same_ch == '0) begin
            free_ff <= free_ff + (NodeBits+1)'(1);
            if (node_ff == '0) root_link_ff <= lk_wd;
         end
         if (cmd.pass2 && node_ff == '0 && level_ff == level_type'(KeyBits-1)) begin
            if (cmd.mode == KIND_INSERT) root_cnt_ff <= root_cnt_ff + count_type'(1);
            if (cmd.mode == KIND_REMOVE) root_cnt_ff <= root_cnt_ff - count_type'(1);
         end
      end
      if (cmd.load) begin
         key_ff   <= req_key;
         node_ff  <= '0;
         level_ff <= level_type'(KeyBits-1);
         best_ff  <= '0;
         rem_ff   <= '0;
         fresh_ff <= 1'b0;
      end else if (cmd.restart) begin
         node_ff  <= '0;
         level_ff <= level_type'(KeyBits-1);
         fresh_ff <= 1'b0;
      end else if (cmd.step) begin
         node_ff  <= node_in;
         fresh_ff <= bump;
         if (level_ff != '0) level_ff <= level_ff - level_type'(1);
         if (cmd.mode == KIND_QUERY && (qsel ? kb : ~kb)) best_ff[level_ff] <= 1'b1;
         if (!cmd.pass2 && same_ch == '0 && rem_ff == '0)
            rem_ff <= node_type'(level_ff) + node_type'(1);
      end
   end

   assign sts.last_level = (level_ff == '0);
   assign sts.missing    = (same_ch == '0) || (cmd.mode == KIND_REMOVE && cn_rd == '0);
   assign sts.root_empty = (root_cnt_ff == '0);
   assign sts.root_full  = &root_cnt_ff;
   assign sts.no_room    = ({1'b0, free_ff} + {2'b0, rem_ff} > (NodeBits+2)'(NodeCount));
   assign best_value     = best_ff;
   assign min_xor        = best_ff ^ key_ff;
   assign stored_count   = root_cnt_ff;
endmodule

// ===== design/xtq_ctrl.sv =====
`timescale 1ns / 1ps
module xtq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_kind,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_status,
   output logic             res_zero,
   output xtq_pkg::cmd_type cmd,
   input  xtq_pkg::sts_type sts
);
   import xtq_pkg::*;
   typedef enum logic [2:0] {IDLE, RD, CNT, STEP, DONE} state_type;
   state_type st_ff;
   logic [1:0] mode_ff, status_ff;
   logic pass2_ff, zero_ff, valid_ff;

   assign req_stall  = (st_ff != IDLE) || (valid_ff && rsp_stall);
   assign rsp_valid  = valid_ff;
   assign rsp_status = status_ff;
   assign res_zero   = zero_ff;

   always_comb begin
      cmd = '0;
      cmd.mode  = mode_ff;
      cmd.pass2 = pass2_ff;
      cmd.load  = (st_ff == IDLE) && req_valid && !req_stall;
      cmd.clr   = cmd.load && req_kind == KIND_CLEAR;
      cmd.step  = (st_ff == STEP);
      cmd.restart = (st_ff == DONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= IDLE; valid_ff <= 1'b0; pass2_ff <= 1'b0;
         mode_ff <= KIND_CLEAR; status_ff <= ST_OK; zero_ff <= 1'b1;
      end else begin
         case (st_ff)
            IDLE: if (cmd.load) begin
               mode_ff <= req_kind; status_ff <= ST_OK; zero_ff <= 1'b1;
               pass2_ff <= 1'b0;
               case (req_kind)
                  KIND_CLEAR: valid_ff <= 1'b1;
                  default: begin
                     valid_ff <= 1'b0; st_ff <= RD;
                  end
               endcase
            end else if (valid_ff && !rsp_stall) valid_ff <= 1'b0;
            RD: begin
               if (mode_ff == KIND_QUERY && sts.root_empty) begin
                  status_ff <= ST_EMPTY; valid_ff <= 1'b1; st_ff <= IDLE;
               end else if (mode_ff == KIND_INSERT && !pass2_ff && sts.root_full) begin
                  status_ff <= ST_FULL; valid_ff <= 1'b1; st_ff <= IDLE;
               end else st_ff <= CNT;
            end
            CNT: st_ff <= STEP;
            STEP: begin
               if (mode_ff == KIND_QUERY) begin
                  if (sts.last_level) begin
                     zero_ff <= 1'b0; valid_ff <= 1'b1; st_ff <= IDLE;
                  end else st_ff <= RD;
               end else if (pass2_ff) begin
                  if (sts.last_level) begin
                     valid_ff <= 1'b1; st_ff <= IDLE;
                  end else st_ff <= RD;
               end else if (mode_ff == KIND_REMOVE && sts.missing) begin
                  status_ff <= ST_NOT_FOUND; valid_ff <= 1'b1; st_ff <= IDLE;
               end else if (sts.last_level || (mode_ff == KIND_INSERT && sts.missing))
                  st_ff <= DONE;
               else st_ff <= RD;
            end
            DONE: begin
               if (mode_ff == KIND_INSERT && sts.no_room) begin
                  status_ff <= ST_FULL; valid_ff <= 1'b1; st_ff <= IDLE;
               end else begin
                  pass2_ff <= 1'b1; st_ff <= RD;
               end
            end
            default: st_ff <= IDLE;
         endcase
      end
   end
endmodule

// ===== design/xor_trie_min_xor_query_unit.sv =====
`timescale 1ns / 1ps
// channel | ports                                   | dir
// req     | req_valid req_stall req_kind req_key    | in
// rsp     | rsp_valid rsp_stall rsp_best_value      | out
//         | rsp_min_xor rsp_status rsp_stored_count |
// one item at a time; each key bit takes a link read, a read of the
// matching child's count and an update; a query walks once from the root,
// insert and remove walk twice with a check state between;
// clear answers in the next cycle, the early refusals before any key bit is walked
// reset is synchronous and empties the trie at once
// a stalled result holds and the next item waits until it is taken
module xor_trie_min_xor_query_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [29:0] req_key,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [29:0] rsp_best_value,
   output logic [29:0] rsp_min_xor,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_stored_count
);
   import xtq_pkg::*;
   cmd_type cmd;
   sts_type sts;
   logic res_zero;
   logic [29:0] bv, mx;

   xtq_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_kind(req_kind), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .res_zero(res_zero), .cmd(cmd), .sts(sts));
   xtq_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_key(req_key), .best_value(bv), .min_xor(mx),
      .stored_count(rsp_stored_count));

   assign rsp_best_value = res_zero ? '0 : bv;
   assign rsp_min_xor    = res_zero ? '0 : mx;

   a_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_best_value == '0 && rsp_min_xor == '0)
      else $error("nonzero result with error status");
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("item taken while result waits");
endmodule
